[rtl/tsf_pkg.sv]
`timescale 1ns / 1ps

package tsf_pkg;

    // Queue depths
    localparam int FIFO_DEPTH_DEF = 32;
    localparam int PLAY_DEPTH_DEF = 8;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int DATA_W   = 16;
    localparam int SIZE_W   = 2;
    localparam int STAMP_W  = 32;
    localparam int ACTION_W = 2;

    // Input word layout: tdata = {time_stamp, write_size, write_data}, tuser = action
    localparam int S_DATA_LSB  = 0;
    localparam int S_SIZE_LSB  = S_DATA_LSB + DATA_W;
    localparam int S_STAMP_LSB = S_SIZE_LSB + SIZE_W;
    localparam int S_FIELDS_W  = S_STAMP_LSB + STAMP_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = ACTION_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_POP   = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    localparam logic [SIZE_W-1:0] SIZE_LO   = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_HI   = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_BOTH = 2'd2;

    typedef struct packed {
        logic clear;
        logic pop;
        logic push_first;
        logic push_second;
    } store_ctl_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic tick;
    } play_ctl_t;

endpackage

[rtl/tsf_sample_store.sv]
`timescale 1ns / 1ps

module tsf_sample_store
    import tsf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int HW = $clog2(FIFO_DEPTH),
    localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  store_ctl_t          ctl,
    input  logic [SAMPLE_W-1:0] first_byte,
    input  logic [SAMPLE_W-1:0] second_byte,
    output logic [SAMPLE_W-1:0] pop_byte,
    output logic [CW-1:0]       count_next
);

    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(FIFO_DEPTH);
    localparam logic [HW-1:0] LAST_C  = HW'(FIFO_DEPTH - 1);

    logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];
    logic [HW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg;
    logic [CW:0]         tail_sum;
    logic [HW-1:0]       tail0, tail1;
    logic                we0, we1;

    // Tail slot: head plus count, wrapped once
    always_comb begin
        tail_sum = {1'b0, CW'(head_reg)} + {1'b0, count_reg};
        if (tail_sum >= DEPTH_W) begin
            tail0 = HW'(tail_sum - DEPTH_W);
        end else begin
            tail0 = HW'(tail_sum);
        end
        tail1 = (tail0 == LAST_C) ? '0 : tail0 + 1'b1;
    end

    // Drop the second byte if the first one fills the store
    assign we0 = ctl.push_first && (count_reg < DEPTH_C);
    assign we1 = ctl.push_second && we0 && (count_reg != DEPTH_C - 1'b1);

    assign pop_byte = (count_reg != '0) ? mem[head_reg] : '0;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.clear) begin
            head_next  = '0;
            count_next = '0;
        end else if (ctl.pop && count_reg != '0) begin
            head_next  = (head_reg == LAST_C) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg + CW'(we0) + CW'(we1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we0) begin
            mem[tail0] <= first_byte;
        end
        if (we1) begin
            mem[tail1] <= second_byte;
        end
    end

endmodule

[rtl/tsf_play_queue.sv]
`timescale 1ns / 1ps

module tsf_play_queue
    import tsf_pkg::*;
#(
    parameter int PLAY_DEPTH = PLAY_DEPTH_DEF,
    localparam int PW = $clog2(PLAY_DEPTH),
    localparam int PCW = $clog2(PLAY_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  play_ctl_t           ctl,
    input  logic [SAMPLE_W-1:0] push_sample,
    input  logic [STAMP_W-1:0]  stamp,
    output logic [SAMPLE_W-1:0] held_next
);

    localparam logic [PCW-1:0] DEPTH_C = PCW'(PLAY_DEPTH);
    localparam logic [PCW:0]   DEPTH_W = (PCW + 1)'(PLAY_DEPTH);
    localparam logic [PW-1:0]  LAST_C  = PW'(PLAY_DEPTH - 1);

    logic [SAMPLE_W-1:0] samples [PLAY_DEPTH];
    logic [STAMP_W-1:0]  times   [PLAY_DEPTH];
    logic [PW-1:0]       head_reg, head_next;
    logic [PCW-1:0]      count_reg, count_next;
    logic [SAMPLE_W-1:0] held_reg;
    logic [PCW:0]        tail_sum;
    logic [PW-1:0]       tail;
    logic                we, take;

    always_comb begin
        tail_sum = {1'b0, PCW'(head_reg)} + {1'b0, count_reg};
        if (tail_sum >= DEPTH_W) begin
            tail = PW'(tail_sum - DEPTH_W);
        end else begin
            tail = PW'(tail_sum);
        end
    end

    // Drop the new entry when the queue is full
    assign we   = ctl.push && (count_reg < DEPTH_C);
    assign take = ctl.tick && (count_reg != '0) && (stamp >= times[head_reg]);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        held_next  = held_reg;
        if (ctl.clear) begin
            head_next  = '0;
            count_next = '0;
            held_next  = '0;
        end else if (take) begin
            held_next  = samples[head_reg];
            head_next  = (head_reg == LAST_C) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (we) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            held_reg  <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            samples[tail] <= push_sample;
            times[tail]   <= stamp;
        end
    end

endmodule

[rtl/timed_sample_fifo_top.sv]
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                                  tuser
// s_       in   write_data[15:0], write_size[17:16],               action[1:0]
//               time_stamp[49:18], zero pad to 56 bits
// m_       out  current_sample[7:0], fill_level[8 +: CW],           -
//               zero pad to whole bytes (CW = 6 at 32 entries)
//
// One word per cycle in and out while m_tready is high; one result word per
// input word. Path: input register, then queue update into the result register.
// Reset (aresetn low, synchronous) empties both queues and clears the playing sample.
// While m_tready is low the result holds and an empty input register takes one more
// word, then s_tready drops.

module timed_sample_fifo_top
    import tsf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int PLAY_DEPTH = PLAY_DEPTH_DEF,
    localparam int CW = $clog2(FIFO_DEPTH + 1),
    localparam int M_TDATA_W = ((SAMPLE_W + CW + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // write_data, write_size, time_stamp
    input  logic [S_TUSER_W-1:0]  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // current_sample, fill_level
);

    logic                 in_valid_reg;
    action_t              action_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 advance, fire;
    store_ctl_t           store_ctl;
    play_ctl_t            play_ctl;
    logic [SAMPLE_W-1:0]  first_byte, second_byte, pop_byte, held_next;
    logic [CW-1:0]        fill_next;

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            action_reg <= action_t'(s_tuser);
            data_reg   <= s_tdata[S_DATA_LSB +: DATA_W];
            size_reg   <= s_tdata[S_SIZE_LSB +: SIZE_W];
            stamp_reg  <= s_tdata[S_STAMP_LSB +: STAMP_W];
        end
    end

    // Decode the word into queue commands
    always_comb begin
        store_ctl   = '0;
        play_ctl    = '0;
        first_byte  = data_reg[SAMPLE_W-1:0];
        second_byte = data_reg[DATA_W-1:SAMPLE_W];
        case (action_reg)
            ACT_WRITE: begin
                store_ctl.push_first = fire;
                if (size_reg == SIZE_BOTH) begin
                    store_ctl.push_second = fire;
                end else if (size_reg != SIZE_LO) begin
                    first_byte = data_reg[DATA_W-1:SAMPLE_W];
                end
            end
            ACT_POP: begin
                store_ctl.pop = fire;
                play_ctl.push = fire;
            end
            ACT_TICK: begin
                play_ctl.tick = fire;
            end
            ACT_CLEAR: begin
                store_ctl.clear = fire;
                play_ctl.clear  = fire;
            end
            default: begin
                store_ctl = '0;
            end
        endcase
    end

    tsf_sample_store #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (store_ctl),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .pop_byte    (pop_byte),
        .count_next  (fill_next)
    );

    tsf_play_queue #(
        .PLAY_DEPTH (PLAY_DEPTH)
    ) u_play (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (play_ctl),
        .push_sample (pop_byte),
        .stamp       (stamp_reg),
        .held_next   (held_next)
    );

    assign m_data_next = M_TDATA_W'({fill_next, held_next});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[SAMPLE_W +: CW] <= CW'(FIFO_DEPTH)))
        else $error("fill level above depth");

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && action_reg == ACT_CLEAR |=> m_data_reg == '0)
        else $error("clear did not empty the queues");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("result word lost");

endmodule

[tb/playback_checker.sv]
`timescale 1ns / 1ps

module playback_checker
    import tsf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int PLAY_DEPTH = PLAY_DEPTH_DEF,
    parameter int FILL_W     = 6,
    parameter int M_W        = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // write_data, write_size, time_stamp
    input  logic [S_TUSER_W-1:0] s_tuser,   // action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_W-1:0]       m_tdata,   // current_sample, fill_level
    output int                   error_count,
    output int                   pending
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [FILL_W-1:0]   fill;
    } playback_t;

    logic [SAMPLE_W-1:0] byte_store [FIFO_DEPTH];
    int                  store_head;
    int                  store_fill;
    logic [SAMPLE_W-1:0] queued_sample [PLAY_DEPTH];
    logic [STAMP_W-1:0]  queued_stamp [PLAY_DEPTH];
    int                  play_head;
    int                  play_fill;
    logic [SAMPLE_W-1:0] playing;
    playback_t           due_results [$];
    int                  result_idx;

    function automatic void clear_playback();
        store_head = 0;
        store_fill = 0;
        play_head  = 0;
        play_fill  = 0;
        playing    = '0;
    endfunction

    function automatic void push_byte(input logic [SAMPLE_W-1:0] b);
        if (store_fill < FIFO_DEPTH) begin
            byte_store[(store_head + store_fill) % FIFO_DEPTH] = b;
            store_fill++;
        end
    endfunction

    function automatic void predict_word(input action_t act, input logic [DATA_W-1:0] data,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [STAMP_W-1:0] stamp);
        logic [SAMPLE_W-1:0] popped;
        int                  slot;
        playback_t           res;
        popped = '0;
        case (act)
            ACT_WRITE: begin
                // a full store ignores the whole halfword
                if (store_fill < FIFO_DEPTH) begin
                    if (size == SIZE_BOTH) begin
                        push_byte(data[7:0]);
                        push_byte(data[15:8]);
                    end else if (size == SIZE_LO) begin
                        push_byte(data[7:0]);
                    end else begin
                        push_byte(data[15:8]);
                    end
                end
            end
            ACT_POP: begin
                // empty store yields silence; the byte is consumed even if the play queue is full
                if (store_fill > 0) begin
                    popped     = byte_store[store_head];
                    store_head = (store_head + 1) % FIFO_DEPTH;
                    store_fill--;
                end
                if (play_fill < PLAY_DEPTH) begin
                    slot                = (play_head + play_fill) % PLAY_DEPTH;
                    queued_sample[slot] = popped;
                    queued_stamp[slot]  = stamp;
                    play_fill++;
                end
            end
            ACT_TICK: begin
                if (play_fill > 0 && stamp >= queued_stamp[play_head]) begin
                    playing   = queued_sample[play_head];
                    play_head = (play_head + 1) % PLAY_DEPTH;
                    play_fill--;
                end
            end
            default: clear_playback();
        endcase
        res.sample = playing;
        res.fill   = FILL_W'(store_fill);
        due_results.push_back(res);
    endfunction

    always @(posedge aclk) begin
        playback_t seen;
        playback_t want;
        if (!aresetn) begin
            clear_playback();
            due_results.delete();
            error_count = 0;
            result_idx  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_word(action_t'(s_tuser), s_tdata[S_DATA_LSB +: DATA_W],
                             s_tdata[S_SIZE_LSB +: SIZE_W], s_tdata[S_STAMP_LSB +: STAMP_W]);
            end
            if (m_tvalid && m_tready) begin
                seen.sample = m_tdata[0 +: SAMPLE_W];
                seen.fill   = m_tdata[SAMPLE_W +: FILL_W];
                if (due_results.size() == 0) begin
                    $display("%0t: word %0d arrived with nothing outstanding (sample %0d fill %0d)",
                             $time, result_idx, $signed(seen.sample), seen.fill);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    if (seen.sample !== want.sample) begin
                        $display("%0t: word %0d current_sample expected %0d, got %0d",
                                 $time, result_idx, $signed(want.sample), $signed(seen.sample));
                        error_count++;
                    end
                    if (seen.fill !== want.fill) begin
                        $display("%0t: word %0d fill_level expected %0d, got %0d",
                                 $time, result_idx, want.fill, seen.fill);
                        error_count++;
                    end
                    if ((m_tdata >> (SAMPLE_W + FILL_W)) !== '0) begin
                        $display("%0t: word %0d padding expected 0, got %h",
                                 $time, result_idx, m_tdata >> (SAMPLE_W + FILL_W));
                        error_count++;
                    end
                end
                result_idx++;
            end
        end
        pending = due_results.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import tsf_pkg::*;

    localparam int FILL_W = $clog2(FIFO_DEPTH_DEF + 1);
    localparam int M_W    = ((SAMPLE_W + FILL_W + 7) / 8) * 8;
    localparam int WORD_TARGET = 400;

    // unused size code, behaves as high byte only
    localparam logic [SIZE_W-1:0] SIZE_ODD = 2'd3;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_RARE} rx_mode_t;
    typedef enum int {SEQ_FILL, SEQ_PLAYOUT, SEQ_MIXED, SEQ_NOISE} seq_kind_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // write_data, write_size, time_stamp
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_W-1:0]       m_tdata;         // current_sample, fill_level

    int           error_count;
    int           pending;
    int           words_sent = 0;
    int           burst_left = 0;
    logic [31:0]  audio_now  = '0;
    rx_mode_t     rx_mode    = RX_STEADY;
    int           rx_left    = 0;

    always #5 aclk = ~aclk;

    timed_sample_fifo_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    playback_checker #(
        .FILL_W (FILL_W),
        .M_W    (M_W)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .pending     (pending)
    );

    // receiver: hold each stall mode for a random stretch
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    task automatic send_word(input action_t act, input logic [DATA_W-1:0] data,
                             input logic [SIZE_W-1:0] size, input logic [STAMP_W-1:0] stamp);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[S_DATA_LSB +: DATA_W]   = data;
        word[S_SIZE_LSB +: SIZE_W]   = size;
        word[S_STAMP_LSB +: STAMP_W] = stamp;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        // end the burst with an idle gap
        if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_write(input logic [SIZE_W-1:0] size);
        send_word(ACT_WRITE, DATA_W'($urandom), size, $urandom);
    endtask

    task automatic send_pop(input int spread);
        send_word(ACT_POP, DATA_W'($urandom), SIZE_W'($urandom_range(0, 3)),
                  audio_now + $urandom_range(0, spread));
    endtask

    task automatic send_tick(input int advance);
        audio_now = audio_now + $urandom_range(0, advance);
        send_word(ACT_TICK, DATA_W'($urandom), SIZE_W'($urandom_range(0, 3)), audio_now);
    endtask

    task automatic run_sequence(input seq_kind_t kind);
        int n;
        int pick;
        case (kind)
            SEQ_FILL: begin
                // fill to one short of full, then a halfword whose high byte is dropped
                send_word(ACT_CLEAR, DATA_W'($urandom), SIZE_W'($urandom_range(0, 3)),
                          $urandom);
                repeat (FIFO_DEPTH_DEF / 2 - 1) send_write(SIZE_BOTH);
                send_write(SIZE_LO);
                send_write(SIZE_BOTH);
                send_write(SIZE_W'($urandom_range(0, 3)));
            end
            SEQ_PLAYOUT: begin
                if ($urandom_range(0, 7) == 0) begin
                    audio_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
                end else if ($urandom_range(0, 7) == 0) begin
                    audio_now = $urandom;
                end
                n = $urandom_range(1, 11);
                repeat (n) send_write(SIZE_W'($urandom_range(0, 3)));
                n = $urandom_range(1, 11);
                repeat (n) send_pop(12);
                n = $urandom_range(1, 12);
                repeat (n) send_tick(4);
            end
            SEQ_MIXED: begin
                n = $urandom_range(8, 24);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        send_write(SIZE_W'($urandom_range(0, 3)));
                    end else if (pick < 70) begin
                        send_pop(8);
                    end else if (pick < 98) begin
                        send_tick(3);
                    end else begin
                        send_word(ACT_CLEAR, DATA_W'($urandom),
                                  SIZE_W'($urandom_range(0, 3)), $urandom);
                    end
                end
            end
            default: begin
                n = $urandom_range(4, 12);
                repeat (n) begin
                    send_word(action_t'($urandom_range(0, 3)), DATA_W'($urandom),
                              SIZE_W'($urandom_range(0, 3)), $urandom);
                end
            end
        endcase
    endtask

    initial begin
        int        seq_idx;
        int        pick;
        seq_kind_t kind;
        burst_left = $urandom_range(1, 40);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty play queue, then silence from an empty store
        send_word(ACT_TICK, 16'h0000, SIZE_LO, 32'h0000_0000);
        send_word(ACT_POP, 16'hFFFF, SIZE_BOTH, 32'h0000_0000);
        send_word(ACT_WRITE, 16'h8001, SIZE_LO, 32'hFFFF_FFFF);
        send_word(ACT_WRITE, 16'h7F80, SIZE_HI, 32'h0000_0000);
        send_word(ACT_WRITE, 16'h80FF, SIZE_BOTH, 32'h0000_0000);
        send_word(ACT_WRITE, 16'h5AA5, SIZE_ODD, 32'h0000_0000);
        send_word(ACT_POP, 16'h0000, SIZE_LO, 32'hFFFF_FFFF);
        // stamp reached exactly, then one short of the top, then at the top
        send_word(ACT_TICK, 16'h0000, SIZE_LO, 32'h0000_0000);
        send_word(ACT_TICK, 16'h0000, SIZE_LO, 32'hFFFF_FFFE);
        send_word(ACT_TICK, 16'h0000, SIZE_LO, 32'hFFFF_FFFF);
        // play the sample extremes
        send_word(ACT_POP, 16'h0000, SIZE_LO, 32'd5);
        send_word(ACT_TICK, 16'hFFFF, SIZE_ODD, 32'd5);
        send_word(ACT_POP, 16'h0000, SIZE_HI, 32'd6);
        send_word(ACT_POP, 16'h0000, SIZE_HI, 32'd6);
        send_word(ACT_TICK, 16'h0000, SIZE_LO, 32'd6);
        send_word(ACT_TICK, 16'h0000, SIZE_LO, 32'd7);
        send_word(ACT_CLEAR, 16'hFFFF, SIZE_BOTH, 32'hFFFF_FFFF);

        seq_idx = 0;
        while (words_sent < WORD_TARGET) begin
            if (seq_idx < 4) begin
                kind = seq_kind_t'(seq_idx);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    kind = SEQ_FILL;
                end else if (pick < 50) begin
                    kind = SEQ_PLAYOUT;
                end else if (pick < 85) begin
                    kind = SEQ_MIXED;
                end else begin
                    kind = SEQ_NOISE;
                end
            end
            run_sequence(kind);
            seq_idx++;
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
